@@ rtl/core/fcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the frame capture controller.
// ----------------------------------------------------------------------------
package fcc_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_CAPTURING = 3'd1,
		MODE_SCANNING  = 3'd2,
		MODE_READY     = 3'd3,
		MODE_FAILED    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_POLL    = 3'd1,
		OP_SCAN    = 3'd2,
		OP_CHUNK   = 3'd3,
		OP_DISCARD = 3'd4,
		OP_NOP     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		FCMD_NONE        = 2'd0,
		FCMD_FLUSH_START = 2'd1,
		FCMD_REWIND      = 2'd2,
		FCMD_FLUSH       = 2'd3
	} fcmd_t;

	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_MAX_FIFO = 2'd2;

	localparam logic [7:0]  MARK_HI      = 8'hFF;
	localparam logic [7:0]  MARK_LO      = 8'hD9;
	localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
	localparam logic [31:0] MAX_FIFO_RST = 32'h0010_0000;

endpackage

@@ rtl/core/fcc_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_fifo
// Small register queue with simultaneous push and pop.
// ----------------------------------------------------------------------------
module fcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/fcc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_front
// Input side: takes words, classifies the opcode and packs the command.
// ----------------------------------------------------------------------------
module fcc_front
	import fcc_pkg::*;
#(
	parameter int LENGTH_BITS = 23,
	parameter int CHUNK_BITS  = 16,
	parameter int CMD_W       = LENGTH_BITS + CHUNK_BITS + 44
) (
	input  logic                   push,
	output logic                   full,
	input  logic [2:0]             opcode,
	input  logic [31:0]            now_ms,
	input  logic                   done_flag,
	input  logic [LENGTH_BITS-1:0] fifo_level,
	input  logic [7:0]             fifo_byte,
	input  logic [CHUNK_BITS-1:0]  chunk_request,
	output logic                   cmd_push,
	output logic [CMD_W-1:0]       cmd_data,
	input  logic                   cmd_full
);

	op_t op;

	always_comb begin
		case (op_t'(opcode))
			OP_START:   op = OP_START;
			OP_POLL:    op = OP_POLL;
			OP_SCAN:    op = OP_SCAN;
			OP_CHUNK:   op = OP_CHUNK;
			OP_DISCARD: op = OP_DISCARD;
			default:    op = OP_NOP;
		endcase
	end

	assign full     = cmd_full;
	assign cmd_push = push && !cmd_full;
	assign cmd_data = {op, now_ms, done_flag, fifo_level, fifo_byte, chunk_request};

endmodule

@@ rtl/core/fcc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_back
// Execution side: capture state machine, frame scan and chunk grants.
// ----------------------------------------------------------------------------
module fcc_back
	import fcc_pkg::*;
#(
	parameter int LENGTH_BITS = 23,
	parameter int CHUNK_BITS  = 16,
	parameter int CMD_W       = LENGTH_BITS + CHUNK_BITS + 44,
	parameter int RES_W       = LENGTH_BITS + CHUNK_BITS + 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   capture_enabled,
	input  logic [15:0]            timeout_ms,
	input  logic [LENGTH_BITS-1:0] max_fifo_bytes,
	input  logic                   cmd_empty,
	input  logic [CMD_W-1:0]       cmd_data,
	output logic                   cmd_pop,
	output logic                   res_push,
	output logic [RES_W-1:0]       res_data,
	input  logic                   res_full
);

	localparam int L  = LENGTH_BITS;
	localparam int C  = CHUNK_BITS;
	localparam int CW = (L > C) ? L : C;

	logic [2:0]   op_bits;
	logic [31:0]  now;
	logic         done;
	logic [L-1:0] flen;
	logic [7:0]   fbyte;
	logic [C-1:0] req;
	op_t          op;

	mode_t        mode_q, mode_d;
	logic [31:0]  start_q, start_d;
	logic [L-1:0] fifo_cnt_q, fifo_cnt_d;
	logic [L-1:0] scan_idx_q, scan_idx_d;
	logic [7:0]   prev_q, prev_d;
	logic [L-1:0] rem_q, rem_d;

	logic         exec;
	logic [31:0]  elapsed;
	logic         timed_out, len_bad, mark, scan_end, start_ok, chunk_ok, req_lt;
	logic [L-1:0] idx_inc, rem_after, left_o;
	logic [C-1:0] grant, grant_o;
	logic         acc;
	fcmd_t        fcmd;

	assign {op_bits, now, done, flen, fbyte, req} = cmd_data;
	assign op = op_t'(op_bits);

	assign exec     = !cmd_empty && !res_full;
	assign cmd_pop  = exec;
	assign res_push = exec;

	assign elapsed   = now - start_q;
	assign timed_out = elapsed > {16'b0, timeout_ms};
	assign len_bad   = (flen == '0) || (flen > max_fifo_bytes);
	assign mark      = (prev_q == MARK_HI) && (fbyte == MARK_LO);
	assign idx_inc   = scan_idx_q + 1'b1;
	assign scan_end  = idx_inc >= fifo_cnt_q;
	assign start_ok  = capture_enabled && (mode_q != MODE_CAPTURING)
		&& (mode_q != MODE_SCANNING);
	assign chunk_ok  = (mode_q == MODE_READY) && (req != '0) && (rem_q != '0);
	assign req_lt    = CW'(req) < CW'(rem_q);
	assign grant     = req_lt ? req : C'(rem_q);
	assign rem_after = rem_q - L'(grant);

	always_comb begin
		mode_d = mode_q;
		if (exec) begin
			case (op)
				OP_START: begin
					if (start_ok) begin
						mode_d = MODE_CAPTURING;
					end
				end
				OP_POLL: begin
					if (mode_q == MODE_CAPTURING) begin
						if (done) begin
							mode_d = len_bad ? MODE_FAILED : MODE_SCANNING;
						end else if (timed_out) begin
							mode_d = MODE_FAILED;
						end
					end
				end
				OP_SCAN: begin
					if (mode_q == MODE_SCANNING) begin
						if (mark) begin
							mode_d = MODE_READY;
						end else if (scan_end) begin
							mode_d = MODE_FAILED;
						end
					end
				end
				OP_CHUNK: begin
					if (chunk_ok && !req_lt) begin
						mode_d = MODE_IDLE;
					end
				end
				OP_DISCARD: mode_d = MODE_IDLE;
				default:    mode_d = mode_q;
			endcase
		end
	end

	always_comb begin
		start_d    = start_q;
		fifo_cnt_d = fifo_cnt_q;
		scan_idx_d = scan_idx_q;
		prev_d     = prev_q;
		rem_d      = rem_q;
		acc        = 1'b0;
		grant_o    = '0;
		fcmd       = FCMD_NONE;
		if (exec) begin
			case (op)
				OP_START: begin
					if (start_ok) begin
						start_d = now;
						rem_d   = '0;
						acc     = 1'b1;
						fcmd    = FCMD_FLUSH_START;
					end
				end
				OP_POLL: begin
					if ((mode_q == MODE_CAPTURING) && done && !len_bad) begin
						fifo_cnt_d = flen;
						scan_idx_d = '0;
						prev_d     = '0;
					end
				end
				OP_SCAN: begin
					if (mode_q == MODE_SCANNING) begin
						if (mark) begin
							rem_d = idx_inc;
							fcmd  = FCMD_REWIND;
						end else begin
							prev_d     = fbyte;
							scan_idx_d = idx_inc;
							if (scan_end) begin
								rem_d = '0;
								fcmd  = FCMD_REWIND;
							end
						end
					end
				end
				OP_CHUNK: begin
					if (chunk_ok) begin
						grant_o = grant;
						acc     = 1'b1;
						rem_d   = rem_after;
					end
				end
				OP_DISCARD: begin
					rem_d = '0;
					fcmd  = FCMD_FLUSH;
				end
				default: begin
					fcmd = FCMD_NONE;
				end
			endcase
		end
	end

	assign left_o   = (mode_d == MODE_READY) ? rem_d : '0;
	assign res_data = {mode_d, left_o, acc, grant_o, fcmd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			start_q    <= '0;
			fifo_cnt_q <= '0;
			scan_idx_q <= '0;
			prev_q     <= '0;
			rem_q      <= '0;
		end else begin
			mode_q     <= mode_d;
			start_q    <= start_d;
			fifo_cnt_q <= fifo_cnt_d;
			scan_idx_q <= scan_idx_d;
			prev_q     <= prev_d;
			rem_q      <= rem_d;
		end
	end

`ifndef SYNTHESIS
	a_ready_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_READY) |-> (rem_q != '0))
		else $error("ready with no bytes left");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SCANNING) |-> (scan_idx_q < fifo_cnt_q))
		else $error("scan index past fifo end");

	a_grant_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && (grant_o != '0)) |-> (acc && (mode_q == MODE_READY)))
		else $error("grant without accept");

	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && (fcmd == FCMD_FLUSH_START)) |=> (mode_q == MODE_CAPTURING))
		else $error("flush-and-start without capture");
`endif

endmodule

@@ rtl/core/frame_capture_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_capture_controller_top
// Camera frame capture controller with APB register port.
// ----------------------------------------------------------------------------
// Sustains one word per clock while full is low: a pushed word goes into a
// two-entry command queue, is executed by the capture state machine as it is
// popped, and its result enters a two-entry result queue before it shows on
// the result ports. full rises only when pops stall long enough that both
// queues fill. Registers:
// 0x0 capture_enabled, 0x4 timeout_ms, 0x8 max_fifo_bytes.
module frame_capture_controller_top
	import fcc_pkg::*;
#(
	parameter int LENGTH_BITS = 23,
	parameter int CHUNK_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   push,
	output logic                   full,
	input  logic [2:0]             opcode,
	input  logic [31:0]            now_ms,
	input  logic                   done_flag,
	input  logic [LENGTH_BITS-1:0] fifo_level,
	input  logic [7:0]             fifo_byte,
	input  logic [CHUNK_BITS-1:0]  chunk_request,
	output logic                   empty,
	input  logic                   pop,
	output logic [2:0]             mode_code,
	output logic [LENGTH_BITS-1:0] bytes_left,
	output logic                   accepted,
	output logic [CHUNK_BITS-1:0]  granted,
	output logic [1:0]             fifo_command
);

	localparam int CMD_W = LENGTH_BITS + CHUNK_BITS + 44;
	localparam int RES_W = LENGTH_BITS + CHUNK_BITS + 6;

	logic                   enable_q;
	logic [15:0]            timeout_q;
	logic [LENGTH_BITS-1:0] max_fifo_q;
	logic                   wr_en;

	logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
	logic             res_push, res_full;
	logic [RES_W-1:0] res_wdata, res_rdata;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			timeout_q  <= TIMEOUT_RST;
			max_fifo_q <= MAX_FIFO_RST[LENGTH_BITS-1:0];
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ENABLE:   enable_q   <= pwdata[0];
				REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
				REG_MAX_FIFO: max_fifo_q <= pwdata[LENGTH_BITS-1:0];
				default:      enable_q   <= enable_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ENABLE:   prdata = {31'b0, enable_q};
			REG_TIMEOUT:  prdata = {16'b0, timeout_q};
			REG_MAX_FIFO: prdata = 32'(max_fifo_q);
			default:      prdata = '0;
		endcase
	end

	fcc_front #(
		.LENGTH_BITS(LENGTH_BITS),
		.CHUNK_BITS (CHUNK_BITS),
		.CMD_W      (CMD_W)
	) u_front (
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.now_ms       (now_ms),
		.done_flag    (done_flag),
		.fifo_level   (fifo_level),
		.fifo_byte    (fifo_byte),
		.chunk_request(chunk_request),
		.cmd_push     (cmd_push),
		.cmd_data     (cmd_wdata),
		.cmd_full     (cmd_full)
	);

	fcc_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_wdata),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_rdata),
		.empty (cmd_empty)
	);

	fcc_back #(
		.LENGTH_BITS(LENGTH_BITS),
		.CHUNK_BITS (CHUNK_BITS),
		.CMD_W      (CMD_W),
		.RES_W      (RES_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.capture_enabled(enable_q),
		.timeout_ms     (timeout_q),
		.max_fifo_bytes (max_fifo_q),
		.cmd_empty      (cmd_empty),
		.cmd_data       (cmd_rdata),
		.cmd_pop        (cmd_pop),
		.res_push       (res_push),
		.res_data       (res_wdata),
		.res_full       (res_full)
	);

	fcc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_wdata),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign {mode_code, bytes_left, accepted, granted, fifo_command} = res_rdata;

endmodule

@@ tb/fcc_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_result_checker
// Scoreboard for the frame capture controller.
// ----------------------------------------------------------------------------
// Snoops register writes on the APB port and every word pushed into the
// block, runs its own copy of the capture state machine to predict the status
// word each input word yields, and compares popped status words field by
// field in order. Register reads are checked against the snooped settings.
module fcc_result_checker
	import fcc_pkg::*;
#(
	parameter int LEN_W   = 23,
	parameter int CHUNK_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	input  logic               push,
	input  logic               full,
	input  logic [2:0]         opcode,
	input  logic [31:0]        now_ms,
	input  logic               done_flag,
	input  logic [LEN_W-1:0]   fifo_level,
	input  logic [7:0]         fifo_byte,
	input  logic [CHUNK_W-1:0] chunk_request,
	input  logic               empty,
	input  logic               pop,
	input  logic [2:0]         mode_code,
	input  logic [LEN_W-1:0]   bytes_left,
	input  logic               accepted,
	input  logic [CHUNK_W-1:0] granted,
	input  logic [1:0]         fifo_command,
	output int                 fail_count,
	output int                 status_owed
);

	typedef struct packed {
		logic [2:0]         opcode;
		logic [31:0]        now_ms;
		logic               done;
		logic [LEN_W-1:0]   fifo_len;
		logic [7:0]         fifo_byte;
		logic [CHUNK_W-1:0] request;
	} capture_word_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [LEN_W-1:0]   left;
		logic               accepted;
		logic [CHUNK_W-1:0] granted;
		logic [1:0]         cmd;
	} capture_status_t;

	// settings as seen on the register port
	logic               cfg_enabled;
	logic [15:0]        cfg_timeout;
	logic [LEN_W-1:0]   cfg_max_fifo;

	// predicted controller state
	mode_t              mode;
	logic [31:0]        start_ms;
	logic [LEN_W-1:0]   fifo_cnt;
	logic [LEN_W-1:0]   scan_idx;
	logic [7:0]         prev_byte;
	logic [LEN_W-1:0]   frame_len;
	logic [LEN_W-1:0]   read_cnt;

	capture_status_t    predicted_status[$];
	capture_word_t      word_in;
	capture_status_t    seen;
	capture_status_t    want;
	logic [31:0]        reg_value;
	int                 mismatches = 0;
	int                 owed = 0;

	assign fail_count  = mismatches;
	assign status_owed = owed;

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] exp_val);
		$display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, exp_val);
		mismatches++;
	endtask

	function automatic capture_status_t advance_capture(input capture_word_t w);
		capture_status_t r;
		logic [31:0] elapsed;
		logic [LEN_W-1:0] remaining;
		r = '0;
		r.cmd = FCMD_NONE;
		case (w.opcode)
		OP_START: begin
			if (cfg_enabled && mode != MODE_CAPTURING && mode != MODE_SCANNING) begin
				mode = MODE_CAPTURING;
				start_ms = w.now_ms;
				frame_len = '0;
				read_cnt = '0;
				r.accepted = 1'b1;
				r.cmd = FCMD_FLUSH_START;
			end
		end
		OP_POLL: begin
			if (mode == MODE_CAPTURING) begin
				elapsed = w.now_ms - start_ms;
				if (w.done) begin
					if (w.fifo_len == '0 || w.fifo_len > cfg_max_fifo) begin
						mode = MODE_FAILED;
					end else begin
						fifo_cnt = w.fifo_len;
						scan_idx = '0;
						prev_byte = '0;
						mode = MODE_SCANNING;
					end
				end else if (elapsed > {16'd0, cfg_timeout}) begin
					mode = MODE_FAILED;
				end
			end
		end
		OP_SCAN: begin
			if (mode == MODE_SCANNING) begin
				if (prev_byte == MARK_HI && w.fifo_byte == MARK_LO) begin
					frame_len = scan_idx + 1'b1;
					read_cnt = '0;
					mode = MODE_READY;
					r.cmd = FCMD_REWIND;
				end else begin
					prev_byte = w.fifo_byte;
					scan_idx = scan_idx + 1'b1;
					if (scan_idx >= fifo_cnt) begin
						frame_len = '0;
						mode = MODE_FAILED;
						r.cmd = FCMD_REWIND;
					end
				end
			end
		end
		OP_CHUNK: begin
			if (mode == MODE_READY && w.request != '0 && frame_len > read_cnt) begin
				remaining = frame_len - read_cnt;
				if (LEN_W'(w.request) < remaining)
					r.granted = w.request;
				else
					r.granted = remaining[CHUNK_W-1:0];
				read_cnt = read_cnt + LEN_W'(r.granted);
				r.accepted = 1'b1;
				if (read_cnt >= frame_len) begin
					mode = MODE_IDLE;
					frame_len = '0;
					read_cnt = '0;
				end
			end
		end
		OP_DISCARD: begin
			mode = MODE_IDLE;
			frame_len = '0;
			read_cnt = '0;
			r.cmd = FCMD_FLUSH;
		end
		default: begin
		end
		endcase
		r.mode = mode;
		r.left = (mode == MODE_READY && frame_len > read_cnt) ? frame_len - read_cnt : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_enabled  <= 1'b0;
			cfg_timeout  <= TIMEOUT_RST;
			cfg_max_fifo <= MAX_FIFO_RST[LEN_W-1:0];
			mode         <= MODE_IDLE;
			start_ms     <= '0;
			fifo_cnt     <= '0;
			scan_idx     <= '0;
			prev_byte    <= '0;
			frame_len    <= '0;
			read_cnt     <= '0;
			predicted_status.delete();
			owed         <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
					REG_ENABLE:   cfg_enabled = pwdata[0];
					REG_TIMEOUT:  cfg_timeout = pwdata[15:0];
					REG_MAX_FIFO: cfg_max_fifo = pwdata[LEN_W-1:0];
					default: begin
					end
					endcase
				end else begin
					case (paddr[3:2])
					REG_ENABLE:   reg_value = {31'd0, cfg_enabled};
					REG_TIMEOUT:  reg_value = {16'd0, cfg_timeout};
					REG_MAX_FIFO: reg_value = 32'(cfg_max_fifo);
					default:      reg_value = '0;
					endcase
					if (prdata != reg_value)
						report_mismatch("prdata", prdata, reg_value);
				end
			end

			if (push && !full) begin
				word_in = '{opcode, now_ms, done_flag, fifo_level, fifo_byte, chunk_request};
				predicted_status.push_back(advance_capture(word_in));
			end

			if (pop && !empty) begin
				seen = '{mode_code, bytes_left, accepted, granted, fifo_command};
				if (predicted_status.size() == 0) begin
					report_mismatch("unexpected word, mode_code", 32'(seen.mode), 32'd0);
				end else begin
					want = predicted_status.pop_front();
					if (seen.mode != want.mode)
						report_mismatch("mode_code", 32'(seen.mode), 32'(want.mode));
					if (seen.left != want.left)
						report_mismatch("bytes_left", 32'(seen.left), 32'(want.left));
					if (seen.accepted != want.accepted)
						report_mismatch("accepted", 32'(seen.accepted),
							32'(want.accepted));
					if (seen.granted != want.granted)
						report_mismatch("granted", 32'(seen.granted), 32'(want.granted));
					if (seen.cmd != want.cmd)
						report_mismatch("fifo_command", 32'(seen.cmd), 32'(want.cmd));
				end
			end

			owed <= predicted_status.size();
		end
	end

endmodule

@@ tb/frame_capture_controller_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_capture_controller_top_tb
// Stimulus and verdict for the frame capture controller.
// ----------------------------------------------------------------------------
// After reset a short directed run walks the capture flow and its corner
// cases, then random phases under several register settings feed mostly
// well-formed capture sessions (start, polls, scan with or without an end
// marker, chunk reads, discard) mixed with noise words. The input side sends
// in bursts, the output side stalls on its own pattern with long hold-offs.
// Checking is done by fcc_result_checker.
module frame_capture_controller_top_tb;
	import fcc_pkg::*;

	localparam int          STALL_LIMIT = 4000;
	localparam logic [2:0]  OP_RSVD5    = 3'd5;
	localparam logic [22:0] LEN_MAX     = 23'h7F_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  opcode = '0;
	logic [31:0] now_ms = '0;
	logic        done_flag = 1'b0;
	logic [22:0] fifo_level = '0;
	logic [7:0]  fifo_byte = '0;
	logic [15:0] chunk_request = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  mode_code;
	logic [22:0] bytes_left;
	logic        accepted;
	logic [15:0] granted;
	logic [1:0]  fifo_command;

	int          fail_count;
	int          status_owed;
	logic [31:0] cur_timeout = 32'd1000;
	logic [22:0] cur_max = 23'h10_0000;
	int          burst_left = 0;
	int          items_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	frame_capture_controller_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.opcode(opcode), .now_ms(now_ms), .done_flag(done_flag),
		.fifo_level(fifo_level), .fifo_byte(fifo_byte), .chunk_request(chunk_request),
		.empty(empty), .pop(pop),
		.mode_code(mode_code), .bytes_left(bytes_left), .accepted(accepted),
		.granted(granted), .fifo_command(fifo_command)
	);

	fcc_result_checker result_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.opcode(opcode), .now_ms(now_ms), .done_flag(done_flag),
		.fifo_level(fifo_level), .fifo_byte(fifo_byte), .chunk_request(chunk_request),
		.empty(empty), .pop(pop),
		.mode_code(mode_code), .bytes_left(bytes_left), .accepted(accepted),
		.granted(granted), .fifo_command(fifo_command),
		.fail_count(fail_count), .status_owed(status_owed)
	);

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [22:0] rand_len();
		return 23'($urandom_range(0, LEN_MAX));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] rand_req();
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// one word into the block, with burst/gap pacing
	task automatic issue(input logic [2:0] op, input logic [31:0] t, input logic dn,
		input logic [22:0] len, input logic [7:0] b, input logic [15:0] req);
		int gap;
		if (burst_left == 0) begin
			burst_left = int'($urandom_range(1, 48));
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		opcode <= op;
		now_ms <= t;
		done_flag <= dn;
		fifo_level <= len;
		fifo_byte <= b;
		chunk_request <= req;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (status_owed != 0) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic en, input logic [15:0] tmo, input logic [22:0] maxf);
		reg_access(1'b1, REG_ENABLE, {31'd0, en});
		reg_access(1'b1, REG_TIMEOUT, {16'd0, tmo});
		reg_access(1'b1, REG_MAX_FIFO, {9'd0, maxf});
		reg_access(1'b0, REG_ENABLE, '0);
		reg_access(1'b0, REG_TIMEOUT, '0);
		reg_access(1'b0, REG_MAX_FIFO, '0);
		cur_timeout = {16'd0, tmo};
		cur_max = maxf;
	endtask

	// start, a few polls, done poll, scan bytes, chunk reads, maybe a discard
	task automatic capture_session();
		logic [31:0] t0;
		logic [31:0] el;
		logic [22:0] len;
		logic [7:0]  b;
		logic [15:0] req;
		int          mark;
		int          span;
		int          nscan;
		t0 = $urandom;
		issue(OP_START, t0, rand_bit(), rand_len(), rand_byte(), rand_req());
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 5))
			0: el = cur_timeout;
			1: el = cur_timeout + 1;
			2: el = $urandom;
			default: el = $urandom_range(0, cur_timeout);
			endcase
			issue(OP_POLL, t0 + el, 1'b0, rand_len(), rand_byte(), rand_req());
		end
		case ($urandom_range(0, 9))
		0: len = '0;
		1: len = (cur_max == LEN_MAX) ? LEN_MAX : cur_max + 1'b1;
		2: len = rand_len();
		3: len = cur_max;
		default: begin
			len = 23'($urandom_range(1, 24));
			if (len > cur_max)
				len = cur_max;
		end
		endcase
		issue(OP_POLL, t0 + $urandom_range(0, cur_timeout), 1'b1, len,
			rand_byte(), rand_req());
		span = (len < 40) ? int'(len) : 40;
		mark = -1;
		if (span >= 2 && $urandom_range(0, 9) < 7)
			mark = int'($urandom_range(0, span - 2));
		if (mark >= 0)
			nscan = mark + 2;
		else
			nscan = (len <= 40) ? int'(len) : int'($urandom_range(1, 40));
		for (int i = 0; i < nscan; i++) begin
			if (i == mark) begin
				b = MARK_HI;
			end else if (mark >= 0 && i == mark + 1) begin
				b = MARK_LO;
			end else begin
				case ($urandom_range(0, 3))
				0: b = MARK_HI;
				1: b = MARK_LO;
				default: b = rand_byte();
				endcase
			end
			issue(OP_SCAN, $urandom, rand_bit(), rand_len(), b, rand_req());
		end
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 5))
			0: req = '0;
			1: req = 16'd1;
			2: req = 16'hFFFF;
			3: req = rand_req();
			default: req = 16'($urandom_range(1, 8));
			endcase
			issue(OP_CHUNK, $urandom, rand_bit(), rand_len(), rand_byte(), req);
		end
		if ($urandom_range(0, 2) == 0)
			issue(OP_DISCARD, $urandom, rand_bit(), rand_len(), rand_byte(), rand_req());
	endtask

	// output side: pop rate redrawn at random, long hold-off after 300 words taken, then every 800
	initial begin : result_sink
		int hold_left;
		int rate;
		int tick;
		int taken;
		int next_hold;
		hold_left = 0;
		rate = 100;
		tick = 0;
		taken = 0;
		next_hold = 300;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				taken++;
			tick++;
			if (tick % 64 == 0) begin
				case ($urandom_range(0, 3))
				0: rate = 100;
				1: rate = 75;
				2: rate = 40;
				default: rate = 10;
				endcase
			end
			if (taken == next_hold && hold_left == 0) begin
				hold_left = 400;
				next_hold += 800;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(1, 100) <= rate);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("frame_capture_controller_top_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		int budget [5];
		int phase_end;
		budget = '{360, 320, 360, 60, 400};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: captures disabled
		load_settings(1'b0, 16'd1000, 23'h10_0000);
		issue(OP_START, 32'd0, 1'b0, '0, '0, '0);
		issue(OP_POLL, 32'd0, 1'b1, 23'd5, '0, '0);
		issue(OP_RSVD5, 32'hFFFF_FFFF, 1'b1, LEN_MAX, 8'hFF, 16'hFFFF);
		drain_results();

		load_settings(1'b1, 16'd0, LEN_MAX);
		issue(OP_START, 32'hFFFF_FFFF, 1'b0, '0, '0, '0);
		issue(OP_START, 32'd3, 1'b0, '0, '0, '0);
		// elapsed wraps to 0, then 1 which is past a zero timeout
		issue(OP_POLL, 32'hFFFF_FFFF, 1'b0, '0, '0, '0);
		issue(OP_POLL, 32'd0, 1'b0, '0, '0, '0);
		issue(OP_START, 32'd5, 1'b0, '0, '0, '0);
		issue(OP_POLL, 32'd5, 1'b1, '0, '0, '0);
		issue(OP_START, 32'd7, 1'b0, '0, '0, '0);
		issue(OP_POLL, 32'd7, 1'b1, LEN_MAX, '0, '0);
		issue(OP_START, 32'd8, 1'b0, '0, '0, '0);
		issue(OP_SCAN, '0, 1'b0, '0, MARK_HI, '0);
		issue(OP_SCAN, '0, 1'b0, '0, MARK_LO, '0);
		issue(OP_CHUNK, '0, 1'b0, '0, '0, 16'd0);
		issue(OP_CHUNK, '0, 1'b0, '0, '0, 16'd1);
		// start from ready drops the frame
		issue(OP_START, 32'd9, 1'b0, '0, '0, '0);
		issue(OP_POLL, 32'd9, 1'b1, 23'd3, '0, '0);
		issue(OP_SCAN, '0, 1'b0, '0, 8'h00, '0);
		issue(OP_SCAN, '0, 1'b0, '0, MARK_HI, '0);
		issue(OP_SCAN, '0, 1'b0, '0, 8'h12, '0);
		issue(OP_CHUNK, '0, 1'b0, '0, '0, 16'hFFFF);
		issue(OP_DISCARD, '0, 1'b0, '0, '0, '0);
		issue(OP_START, 32'd11, 1'b0, '0, '0, '0);
		issue(OP_POLL, 32'd11, 1'b1, 23'd4, '0, '0);
		issue(OP_SCAN, '0, 1'b0, '0, MARK_HI, '0);
		issue(OP_SCAN, '0, 1'b0, '0, MARK_LO, '0);
		issue(OP_CHUNK, '0, 1'b0, '0, '0, 16'hFFFF);
		drain_results();

		for (int p = 0; p < 5; p++) begin
			case (p)
			0: load_settings(1'b1, 16'd1000, 23'h10_0000);
			1: load_settings(1'b1, 16'hFFFF, 23'd1);
			2: load_settings(1'b1, 16'd0, LEN_MAX);
			3: load_settings(1'b0, rand_req(), 23'($urandom_range(1, LEN_MAX)));
			default: load_settings(1'b1, rand_req(), 23'($urandom_range(1, 64)));
			endcase
			phase_end = items_sent + budget[p];
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 15)
					issue(3'($urandom_range(0, 7)), $urandom, rand_bit(),
						rand_len(), rand_byte(), rand_req());
				else
					capture_session();
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("frame_capture_controller_top_tb: done, clean");
		else
			$display("frame_capture_controller_top_tb: done, errors");
		$finish;
	end

endmodule
